// File: hdl/ibpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibpd_pkg
// Shared constants and types for the hashed image block framer.
// ----------------------------------------------------------------------------
package ibpd_pkg;

  localparam int unsigned BLOCK_BYTES_DEF = 180;
  localparam logic [31:0] HASH_SEED       = 32'd5381;
  localparam logic [15:0] SYNC_VALUE      = 16'h54A8;
  localparam logic [2:0]  TYPE_GRAY       = 3'd0;
  localparam logic [7:0]  WIDTH_RST       = 8'd64;
  localparam logic [7:0]  HEIGHT_RST      = 8'd64;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [3:0] {
    ST_FILL  = 4'b0001,
    ST_HEAD  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_WORD  = 4'b1000
  } state_t;

  typedef struct packed {
    logic accept;
    logic show_header;
    logic next_word;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic blk_close;
    logic last_word;
  } sts_t;

endpackage

// File: hdl/ibpd_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibpd_pix_if
// Pixel input channel: one grayscale byte per word.
// ----------------------------------------------------------------------------
interface ibpd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// File: hdl/ibpd_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibpd_res_if
// Result channel: block headers and payload words.
// ----------------------------------------------------------------------------
interface ibpd_res_if;
  logic        valid;
  logic        ready;
  logic        is_header;
  logic [15:0] sync_word;
  logic [2:0]  piece_type;
  logic [31:0] block_hash;
  logic [7:0]  frame_stamp;
  logic [7:0]  width_out;
  logic [7:0]  height_out;
  logic [15:0] start_index;
  logic [31:0] payload_word;
  logic [2:0]  bytes_valid;
  logic        last;

  modport source (
    output valid, output is_header, output sync_word, output piece_type,
    output block_hash, output frame_stamp, output width_out, output height_out,
    output start_index, output payload_word, output bytes_valid, output last,
    input ready
  );
  modport sink (
    input valid, input is_header, input sync_word, input piece_type,
    input block_hash, input frame_stamp, input width_out, input height_out,
    input start_index, input payload_word, input bytes_valid, input last,
    output ready
  );
endinterface

// File: hdl/ibpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibpd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ibpd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 45,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ibpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibpd_ctrl
// Sequencer: fill a block, send its header, then read out payload words.
// ----------------------------------------------------------------------------
module ibpd_ctrl
  import ibpd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd             = '0;
    case (state_r)
      ST_FILL: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.blk_close) begin
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        out_valid       = 1'b1;
        cmd.show_header = 1'b1;
        if (out_ready) begin
          state_nxt = ST_WORD;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_WORD;
      end
      ST_WORD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last_word) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_FILL;
          end else begin
            cmd.next_word = 1'b1;
            state_nxt     = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

endmodule

// File: hdl/ibpd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibpd_dpath
// Datapath: block store banks, djb2 hash, frame counters, result fields.
// ----------------------------------------------------------------------------
module ibpd_dpath
  import ibpd_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [7:0]           pixel,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 is_header,
  output logic [15:0]          sync_word,
  output logic [2:0]           piece_type,
  output logic [31:0]          block_hash,
  output logic [7:0]           frame_stamp,
  output logic [7:0]           width_out,
  output logic [7:0]           height_out,
  output logic [15:0]          start_index,
  output logic [31:0]          payload_word,
  output logic [2:0]           bytes_valid,
  output logic                 last
);

  localparam int unsigned WORDS   = (BLOCK_BYTES + 3) / 4;
  localparam int unsigned WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FILL_W  = $clog2(BLOCK_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES - 1);

  logic [7:0]         width_r, height_r;
  logic [31:0]        hash_r;
  logic [FILL_W-1:0]  fill_r;
  logic [15:0]        pos_r;
  logic [15:0]        base_r;
  logic [7:0]         stamp_r;
  logic               frame_end_r;
  logic [WORD_AW-1:0] idx_r;

  logic [15:0]        frame_len;
  logic [16:0]        next_pos;
  logic               frame_end;
  logic [31:0]        hash_nxt;
  logic [WORD_AW-1:0] waddr;
  logic [31:0]        rd_word;
  logic [FILL_W-1:0]  word_base;
  logic [FILL_W-1:0]  remain;
  logic [2:0]         nbytes;
  logic [31:0]        mask;

  assign frame_len = {8'd0, width_r} * {8'd0, height_r};
  assign next_pos  = {1'b0, pos_r} + 17'd1;
  assign frame_end = next_pos >= {1'b0, frame_len};
  assign hash_nxt  = (hash_r << 5) + hash_r + {24'd0, pixel};

  assign sts.blk_close = frame_end || (fill_r == FILL_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= HASH_SEED;
      fill_r      <= '0;
      pos_r       <= '0;
      base_r      <= '0;
      stamp_r     <= '0;
      frame_end_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (cmd.accept) begin
        hash_r      <= hash_nxt;
        fill_r      <= fill_r + FILL_W'(1);
        pos_r       <= next_pos[15:0];
        frame_end_r <= frame_end;
      end
      if (cmd.next_word) begin
        idx_r <= idx_r + WORD_AW'(1);
      end
      if (cmd.commit) begin
        hash_r <= HASH_SEED;
        fill_r <= '0;
        idx_r  <= '0;
        if (frame_end_r) begin
          stamp_r <= stamp_r + 8'd1;
          pos_r   <= '0;
          base_r  <= '0;
        end else begin
          base_r <= base_r + 16'(fill_r);
        end
      end
    end
  end

  // store byte lanes: bank = fill[1:0], row = fill / 4
  assign waddr = WORD_AW'(fill_r >> 2);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    ibpd_ram #(
      .WIDTH (8),
      .DEPTH (WORDS),
      .AW    (WORD_AW)
    ) u_bank (
      .clk   (clk),
      .we    (cmd.accept && (fill_r[1:0] == 2'(b))),
      .waddr (waddr),
      .wdata (pixel),
      .raddr (idx_r),
      .rdata (rd_word[8*b +: 8])
    );
  end

  assign word_base = FILL_W'({idx_r, 2'b00});
  assign remain    = fill_r - word_base;
  assign nbytes    = (remain >= FILL_W'(4)) ? 3'd4 : remain[2:0];
  assign sts.last_word = remain <= FILL_W'(4);

  always_comb begin
    mask = '0;
    for (int k = 0; k < 4; k++) begin
      mask[8*k +: 8] = (3'(k) < nbytes) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    is_header    = cmd.show_header;
    sync_word    = '0;
    piece_type   = '0;
    block_hash   = '0;
    frame_stamp  = '0;
    width_out    = '0;
    height_out   = '0;
    start_index  = '0;
    payload_word = '0;
    bytes_valid  = '0;
    last         = 1'b0;
    if (cmd.show_header) begin
      sync_word   = SYNC_VALUE;
      piece_type  = TYPE_GRAY;
      block_hash  = hash_r;
      frame_stamp = stamp_r;
      width_out   = width_r;
      height_out  = height_r;
      start_index = base_r;
    end else begin
      payload_word = rd_word & mask;
      bytes_valid  = nbytes;
      last         = sts.last_word;
    end
  end

endmodule

// File: hdl/image_block_packetizer_djb2_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_block_packetizer_djb2_core
// Frames a grayscale pixel stream into hashed blocks with headers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one pixel byte per word, raster order. out_ch carries a
//   header word (is_header=1: sync 0x54A8, type 0, djb2 hash, frame stamp,
//   sizes, start offset) followed by the block's payload, four bytes per
//   word, first byte lowest, last set on the final word.
//   cfg_we/cfg_index/cfg_data write frame_width (index 0) and frame_height
//   (index 1); write only while the block is idle.
//   Pixels are taken one per cycle while a block fills. A block closes after
//   BLOCK_BYTES bytes or at frame end; input then stalls while the burst is
//   sent. The header shows in the cycle after the closing byte and the first
//   payload word in the cycle after the header is taken; each later word
//   passes a fetch state (one registered read of the four byte-lane RAMs)
//   and then an output state. A stalled receiver holds the current word and
//   the whole block.
//   Reset (rst_n, synchronous) restores 64x64 sizes, the hash seed, the
//   frame stamp and all counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module image_block_packetizer_djb2_core
  import ibpd_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  ibpd_pix_if.sink             in_ch,
  ibpd_res_if.source           out_ch
);

  cmd_t cmd;
  sts_t sts;

  ibpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ibpd_dpath #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel        (in_ch.pixel),
    .cmd          (cmd),
    .sts          (sts),
    .is_header    (out_ch.is_header),
    .sync_word    (out_ch.sync_word),
    .piece_type   (out_ch.piece_type),
    .block_hash   (out_ch.block_hash),
    .frame_stamp  (out_ch.frame_stamp),
    .width_out    (out_ch.width_out),
    .height_out   (out_ch.height_out),
    .start_index  (out_ch.start_index),
    .payload_word (out_ch.payload_word),
    .bytes_valid  (out_ch.bytes_valid),
    .last         (out_ch.last)
  );

endmodule
